FILE: hw/rtl/fmct_pkg.sv
// Shared types, constants and register map of the FM composite test signal generator.
package fmct_pkg;

    // Default sine table size, log2 of entries per turn
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Register map, index = paddr[4:2]
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PILOT_STEP        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TONE_STEP         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SUBCARRIER_OFFSET = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TONE_AMPLITUDE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEVIATION_STEP    = 3'd4;

    localparam int PADDR_W = 5;
    localparam int AMP_W   = 15;

    // Register reset values
    localparam logic [31:0]      PILOT_STEP_RST        = 32'd318767104;
    localparam logic [31:0]      TONE_STEP_RST         = 32'd16726786;
    localparam logic [31:0]      SUBCARRIER_OFFSET_RST = 32'd0;
    localparam logic [AMP_W-1:0] TONE_AMPLITUDE_RST    = 15'd9830;
    localparam logic [31:0]      DEVIATION_STEP_RST    = 32'd1258291200;

    // Composite weights in Q14: 0.09 and 0.04
    localparam logic signed [15:0] PILOT_WEIGHT = 16'sd1475;
    localparam logic signed [15:0] SUB_WEIGHT   = 16'sd655;

    // pi/2 in Q30, used to build the quarter-wave table
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    typedef struct packed {
        logic [31:0]      pilot_step;
        logic [31:0]      tone_step;
        logic [31:0]      subcarrier_offset;
        logic [AMP_W-1:0] tone_amplitude;
        logic [31:0]      deviation_step;
    } cfg_t;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LK_TONE,
        OP_MAC_TONE,
        OP_MAC_PILOT,
        OP_MAC_SUB,
        OP_ROUND,
        OP_DEV,
        OP_CARRIER,
        OP_COS,
        OP_SIN,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

FILE: hw/rtl/fmct_ctrl.sv
// Sequencer that walks one sample through the datapath steps.
module fmct_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_tick,
    output logic          s_ready,
    output fmct_pkg::cmd_t cmd,
    input  fmct_pkg::sts_t sts
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_LK_TONE   = 11'b00000000010,
        ST_MAC_TONE  = 11'b00000000100,
        ST_MAC_PILOT = 11'b00000001000,
        ST_MAC_SUB   = 11'b00000010000,
        ST_ROUND     = 11'b00000100000,
        ST_DEV       = 11'b00001000000,
        ST_CARRIER   = 11'b00010000000,
        ST_COS       = 11'b00100000000,
        ST_SIN       = 11'b01000000000,
        ST_LOAD      = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = fmct_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                // a beat with tick low is taken and dropped
                if (s_valid && s_tick) begin
                    state_next = ST_LK_TONE;
                end
            end
            ST_LK_TONE: begin
                cmd.op     = fmct_pkg::OP_LK_TONE;
                state_next = ST_MAC_TONE;
            end
            ST_MAC_TONE: begin
                cmd.op     = fmct_pkg::OP_MAC_TONE;
                state_next = ST_MAC_PILOT;
            end
            ST_MAC_PILOT: begin
                cmd.op     = fmct_pkg::OP_MAC_PILOT;
                state_next = ST_MAC_SUB;
            end
            ST_MAC_SUB: begin
                cmd.op     = fmct_pkg::OP_MAC_SUB;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.op     = fmct_pkg::OP_ROUND;
                state_next = ST_DEV;
            end
            ST_DEV: begin
                cmd.op     = fmct_pkg::OP_DEV;
                state_next = ST_CARRIER;
            end
            ST_CARRIER: begin
                cmd.op     = fmct_pkg::OP_CARRIER;
                state_next = ST_COS;
            end
            ST_COS: begin
                cmd.op     = fmct_pkg::OP_COS;
                state_next = ST_SIN;
            end
            ST_SIN: begin
                cmd.op     = fmct_pkg::OP_SIN;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.op = fmct_pkg::OP_LOAD;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/fmct_dp.sv
// Phase accumulators, sine lookup, shared multiplier and output register.
module fmct_dp #(
    parameter int SINE_TABLE_BITS = fmct_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fmct_pkg::cfg_t     cfg,
    input  fmct_pkg::cmd_t     cmd,
    output fmct_pkg::sts_t     sts,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_composite_sample,
    output logic [7:0]         m_i_byte,
    output logic [7:0]         m_q_byte
);

    localparam int TB      = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (TB - 2);

    // sin(r * (pi/2) / 2^(bits-2)) in Q14, Taylor series in Q30
    function automatic logic [14:0] quarter_sine(input int unsigned r, input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        x  = (longint'(r) * fmct_pkg::HALF_PI_Q30) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = fmct_pkg::ONE_Q30 - x2 / 72;
        t  = fmct_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = fmct_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = fmct_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        v  = (s + 64'd32768) >> 16;
        if (v > 64'd16384) begin
            v = 64'd16384;
        end
        return v[14:0];
    endfunction

    // offset-binary byte: floor((255 * (c + 16384) + 16384) / 32768)
    function automatic logic [7:0] to_byte(input logic signed [15:0] c);
        logic [15:0] u;
        logic [23:0] p;
        logic [23:0] r;
        u = 16'(c + 16'sd16384);
        p = ({8'd0, u} << 8) - {8'd0, u};
        r = p + 24'd16384;
        return r[22:15];
    endfunction

    // quarter-wave table, entries 0..QUARTER
    logic [14:0] qtab [QUARTER+1];

    for (genvar r = 0; r <= QUARTER; r++) begin : g_qtab
        assign qtab[r] = quarter_sine(r, TB);
    end

    logic [31:0]        pilot_phase_reg, tone_phase_reg, carrier_phase_reg;
    logic [31:0]        sub_phase_reg;
    logic signed [15:0] sin_reg;
    logic signed [31:0] acc_reg;
    logic signed [15:0] comp_reg;
    logic [45:0]        prod_reg;
    logic [7:0]         i_reg;
    logic [7:0]         q_reg;
    logic               m_valid_reg;
    logic signed [15:0] m_comp_reg;
    logic [7:0]         m_i_reg, m_q_reg;

    // shared sine lookup
    logic [31:0]        lk_phase;
    logic               lk_cos;
    logic [TB-1:0]      lk_idx;
    logic [1:0]         lk_quad;
    logic [TB-3:0]      lk_r;
    logic [TB-2:0]      lk_ridx;
    logic [14:0]        lk_mag;
    logic signed [15:0] lk_val;

    always_comb begin
        lk_phase = carrier_phase_reg;
        lk_cos   = 1'b0;
        unique case (cmd.op)
            fmct_pkg::OP_LK_TONE:   lk_phase = tone_phase_reg;
            fmct_pkg::OP_MAC_TONE:  lk_phase = pilot_phase_reg;
            fmct_pkg::OP_MAC_PILOT: lk_phase = sub_phase_reg;
            fmct_pkg::OP_COS:       lk_cos   = 1'b1;
            default:                lk_phase = carrier_phase_reg;
        endcase
    end

    assign lk_idx  = lk_phase[31 -: TB] + (lk_cos ? TB'(QUARTER) : TB'(0));
    assign lk_quad = lk_idx[TB-1 -: 2];
    assign lk_r    = lk_idx[TB-3:0];
    assign lk_ridx = lk_quad[0] ? ((TB-1)'(QUARTER) - {1'b0, lk_r}) : {1'b0, lk_r};
    assign lk_mag  = qtab[lk_ridx];
    assign lk_val  = lk_quad[1] ? -$signed({1'b0, lk_mag}) : $signed({1'b0, lk_mag});

    // weight times sine
    logic signed [15:0] mul_a;
    logic signed [31:0] mul_p;

    always_comb begin
        unique case (cmd.op)
            fmct_pkg::OP_MAC_TONE:  mul_a = $signed({1'b0, cfg.tone_amplitude});
            fmct_pkg::OP_MAC_PILOT: mul_a = fmct_pkg::PILOT_WEIGHT;
            default:                mul_a = fmct_pkg::SUB_WEIGHT;
        endcase
    end

    assign mul_p = mul_a * sin_reg;

    // round Q28 to Q14 and saturate
    logic signed [31:0] rnd;
    logic signed [15:0] comp_sat;

    assign rnd = (acc_reg + 32'sd8192) >>> 14;

    always_comb begin
        priority if (rnd > 32'sd32767) begin
            comp_sat = 16'sh7fff;
        end else if (rnd < -32'sd32768) begin
            comp_sat = 16'sh8000;
        end else begin
            comp_sat = rnd[15:0];
        end
    end

    // carrier increment
    logic signed [48:0] dev_p;
    logic [45:0]        dev_r;

    assign dev_p = $signed({1'b0, cfg.deviation_step}) * comp_reg;
    assign dev_r = prod_reg + 46'd8192;

    logic out_free;
    assign out_free     = !m_valid_reg || m_ready;
    assign sts.out_free = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pilot_phase_reg   <= '0;
            tone_phase_reg    <= '0;
            carrier_phase_reg <= '0;
        end else begin
            unique case (cmd.op)
                fmct_pkg::OP_ROUND: begin
                    pilot_phase_reg <= pilot_phase_reg + cfg.pilot_step;
                    tone_phase_reg  <= tone_phase_reg + cfg.tone_step;
                end
                fmct_pkg::OP_CARRIER: begin
                    carrier_phase_reg <= carrier_phase_reg + dev_r[45:14];
                end
                default: begin
                end
            endcase
        end
    end

    // working registers, no reset
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            fmct_pkg::OP_LK_TONE: begin
                sin_reg       <= lk_val;
                acc_reg       <= '0;
                sub_phase_reg <= pilot_phase_reg + {pilot_phase_reg[30:0], 1'b0}
                               + cfg.subcarrier_offset;
            end
            fmct_pkg::OP_MAC_TONE, fmct_pkg::OP_MAC_PILOT: begin
                sin_reg <= lk_val;
                acc_reg <= acc_reg + mul_p;
            end
            fmct_pkg::OP_MAC_SUB: begin
                acc_reg <= acc_reg + mul_p;
            end
            fmct_pkg::OP_ROUND: begin
                comp_reg <= comp_sat;
            end
            fmct_pkg::OP_DEV: begin
                prod_reg <= dev_p[45:0];
            end
            fmct_pkg::OP_COS: begin
                i_reg <= to_byte(lk_val);
            end
            fmct_pkg::OP_SIN: begin
                q_reg <= to_byte(lk_val);
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == fmct_pkg::OP_LOAD && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == fmct_pkg::OP_LOAD && out_free) begin
            m_comp_reg <= comp_reg;
            m_i_reg    <= i_reg;
            m_q_reg    <= q_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_composite_sample = m_comp_reg;
    assign m_i_byte           = m_i_reg;
    assign m_q_byte           = m_q_reg;

endmodule

FILE: hw/rtl/fm_composite_test_signal_generator_core.sv
// FM composite test signal generator: APB register file, sequencer and datapath.
//
// Every accepted beat with s_tick high yields one result beat: the composite
// baseband value (signed Q2.14, 1.0 = full deviation) made of the program tone
// times tone_amplitude, 0.09 of the 19 kHz pilot and 0.04 of a subcarrier at
// three times the pilot phase plus subcarrier_offset, together with the cosine
// and sine of the FM carrier phase after it has been advanced by
// deviation_step times that composite, as offset-binary bytes (i_byte, q_byte).
// A beat with s_tick low is taken and has no effect. From acceptance to the
// result register the sequencer steps through three sine lookups and
// multiply-accumulates on one shared multiplier, the rounding, the deviation
// multiply, the carrier update, two lookups for the output bytes and the load;
// s_ready is high only while the sequencer is idle, so a new beat is taken only
// after the current sample has left the load step. If the result register is
// still full at the load step, the sequencer waits there until it frees up.
// A finished result waits in its own register, so the next sample is already
// being computed while it is held. The sine table is a constant quarter wave
// of 2^(SINE_TABLE_BITS-2)+1 entries; no clearing pass is needed after reset.
// Registers are written over APB at byte addresses 4*index and should be
// changed only while the block is idle.
module fm_composite_test_signal_generator_core #(
    parameter int SINE_TABLE_BITS = fmct_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fmct_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_tick,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [15:0]             m_composite_sample,
    output logic [7:0]                     m_i_byte,
    output logic [7:0]                     m_q_byte
);

    fmct_pkg::cfg_t cfg_reg;
    fmct_pkg::cmd_t cmd;
    fmct_pkg::sts_t sts;

    logic [fmct_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[fmct_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes; indexes past the map are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pilot_step        <= fmct_pkg::PILOT_STEP_RST;
            cfg_reg.tone_step         <= fmct_pkg::TONE_STEP_RST;
            cfg_reg.subcarrier_offset <= fmct_pkg::SUBCARRIER_OFFSET_RST;
            cfg_reg.tone_amplitude    <= fmct_pkg::TONE_AMPLITUDE_RST;
            cfg_reg.deviation_step    <= fmct_pkg::DEVIATION_STEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                fmct_pkg::REG_PILOT_STEP:        cfg_reg.pilot_step        <= pwdata;
                fmct_pkg::REG_TONE_STEP:         cfg_reg.tone_step         <= pwdata;
                fmct_pkg::REG_SUBCARRIER_OFFSET: cfg_reg.subcarrier_offset <= pwdata;
                fmct_pkg::REG_TONE_AMPLITUDE:
                    cfg_reg.tone_amplitude <= pwdata[fmct_pkg::AMP_W-1:0];
                fmct_pkg::REG_DEVIATION_STEP:    cfg_reg.deviation_step    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // read-back
    always_comb begin
        unique case (reg_idx)
            fmct_pkg::REG_PILOT_STEP:        prdata = cfg_reg.pilot_step;
            fmct_pkg::REG_TONE_STEP:         prdata = cfg_reg.tone_step;
            fmct_pkg::REG_SUBCARRIER_OFFSET: prdata = cfg_reg.subcarrier_offset;
            fmct_pkg::REG_TONE_AMPLITUDE:
                prdata = {{(32 - fmct_pkg::AMP_W){1'b0}}, cfg_reg.tone_amplitude};
            fmct_pkg::REG_DEVIATION_STEP:    prdata = cfg_reg.deviation_step;
            default:                         prdata = '0;
        endcase
    end

    // sequencer: one step of the sample per cycle unless the load step waits
    fmct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_tick  (s_tick),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // accumulators, lookup, multiplier and result register
    fmct_dp #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .cmd                (cmd),
        .sts                (sts),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_composite_sample (m_composite_sample),
        .m_i_byte           (m_i_byte),
        .m_q_byte           (m_q_byte)
    );

endmodule
